// File: src/threshold_crossing_time_measure_macros.svh
// Assertion helpers used by the top-level module to check the block.
`ifndef THRESHOLD_CROSSING_TIME_MEASURE_MACROS_SVH
`define THRESHOLD_CROSSING_TIME_MEASURE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCTM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tctm_pkg.sv
package tctm_pkg;

  localparam int TIME_BITS_DEF  = 48;
  localparam int VALUE_BITS_DEF = 32;
  localparam int CFG_IDX_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD    = 3'd0,
    CFG_FALLING_EDGE = 3'd1,
    CFG_REPORT_LAST  = 3'd2,
    CFG_WINDOW_START = 3'd3,
    CFG_WINDOW_END   = 3'd4
  } tctm_cfg_idx_t;

  typedef enum logic [1:0] {
    PH_WAITING,
    PH_READY,
    PH_DONE
  } tctm_phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_REPORT
  } tctm_state_t;

  typedef struct packed {
    logic load_sample;
    logic load_lower;
    logic div_start;
    logic div_step;
    logic report;
  } tctm_cmd_t;

  typedef struct packed {
    logic in_window;
    logic beyond;
    logic past;
    logic eor;
    logic div_last;
    logic report_last;
  } tctm_status_t;

endpackage

// File: src/tctm_if.sv
interface tctm_in_if #(
  parameter int TIME_BITS  = tctm_pkg::TIME_BITS_DEF,
  parameter int VALUE_BITS = tctm_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [TIME_BITS-1:0]         sample_time;
  logic signed [VALUE_BITS-1:0] sample_value;
  logic                         end_of_record;

  modport source (output valid, output sample_time, output sample_value,
                  output end_of_record, input ready);
  modport sink (input valid, input sample_time, input sample_value,
                input end_of_record, output ready);
endinterface

interface tctm_out_if #(
  parameter int TIME_BITS = tctm_pkg::TIME_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] crossing_time;
  logic                 found;

  modport source (output valid, output crossing_time, output found, input ready);
  modport sink (input valid, input crossing_time, input found, output ready);
endinterface

interface tctm_cfg_if #(
  parameter int DATA_W = tctm_pkg::TIME_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [tctm_pkg::CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]              data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/threshold_crossing_time_measure.sv
// Channel  Direction  Payload
// in_ch    sink       sample_time, sample_value, end_of_record
// out_ch   source     crossing_time, found
// cfg_ch   sink       index, data (ready outside reset)
//
// A sample without a crossing is accepted in ST_IDLE and evaluated in ST_EVAL.
// A completing sample then steps the two-bit-per-cycle divider in ST_DIV over the
// whole time span, rounded up to an even width.
// An end-of-record sample then passes through ST_REPORT, which loads the output register.
// Reset is synchronous and active low and restores configuration and control state.
// A result waiting on out_ch stalls the block only at the next end-of-record.
`include "threshold_crossing_time_measure_macros.svh"

module threshold_crossing_time_measure #(
  parameter int TIME_BITS  = tctm_pkg::TIME_BITS_DEF,
  parameter int VALUE_BITS = tctm_pkg::VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tctm_in_if.sink    in_ch,
  tctm_out_if.source out_ch,
  tctm_cfg_if.sink   cfg_ch
);
  import tctm_pkg::*;

  localparam int CFG_DW = (TIME_BITS > VALUE_BITS) ? TIME_BITS : VALUE_BITS;

  tctm_cmd_t    cmd;
  tctm_status_t status;

  assign cfg_ch.ready = rst_n;

  tctm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tctm_datapath #(
    .TIME_BITS  (TIME_BITS),
    .VALUE_BITS (VALUE_BITS),
    .CFG_DW     (CFG_DW)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_ch.valid && cfg_ch.ready),
    .cfg_index (cfg_ch.index),
    .cfg_data  (CFG_DW'(cfg_ch.data)),
    .in_time   (in_ch.sample_time[TIME_BITS-1:0]),
    .in_value  (in_ch.sample_value[VALUE_BITS-1:0]),
    .in_eor    (in_ch.end_of_record),
    .cmd       (cmd),
    .status    (status),
    .out_time  (out_ch.crossing_time),
    .out_found (out_ch.found)
  );

  `TCTM_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "ready held")
  `TCTM_ASSERT_IMP(a_report_slot_free, cmd.report, !out_ch.valid || out_ch.ready, "lost result")
  `TCTM_ASSERT_NEXT(a_report_shows, cmd.report, out_ch.valid, "report not presented")
  `TCTM_ASSERT_NEXT(a_div_runs, cmd.div_start, cmd.div_step, "divider not stepped")

endmodule

// File: src/tctm_datapath.sv
module tctm_datapath #(
  parameter int TIME_BITS  = tctm_pkg::TIME_BITS_DEF,
  parameter int VALUE_BITS = tctm_pkg::VALUE_BITS_DEF,
  parameter int CFG_DW     = tctm_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr,
  input  logic [tctm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]              cfg_data,
  input  logic [TIME_BITS-1:0]           in_time,
  input  logic signed [VALUE_BITS-1:0]   in_value,
  input  logic                           in_eor,
  input  tctm_pkg::tctm_cmd_t            cmd,
  output tctm_pkg::tctm_status_t         status,
  output logic [TIME_BITS-1:0]           out_time,
  output logic                           out_found
);
  import tctm_pkg::*;

  localparam int DW     = VALUE_BITS + 1;
  localparam int SPAN_W = TIME_BITS + (TIME_BITS % 2);
  localparam int STEPS  = SPAN_W / 2;
  localparam int CNT_W  = $clog2(STEPS);

  logic signed [VALUE_BITS-1:0] thr_r;
  logic                         falling_r;
  logic                         last_r;
  logic [TIME_BITS-1:0]         ws_r;
  logic [TIME_BITS-1:0]         we_r;

  logic [TIME_BITS-1:0]         t_r;
  logic signed [VALUE_BITS-1:0] v_r;
  logic                         eor_r;
  logic [TIME_BITS-1:0]         lt_r;
  logic signed [VALUE_BITS-1:0] lv_r;
  logic [TIME_BITS-1:0]         best_r;
  logic                         found_r;

  logic [DW-1:0]                num_r;
  logic [DW-1:0]                den_r;
  logic [DW-1:0]                rem_r;
  logic [TIME_BITS-1:0]         q_r;
  logic [SPAN_W-1:0]            span_r;
  logic [CNT_W-1:0]             cnt_r;

  logic [TIME_BITS-1:0]         out_time_r;
  logic                         out_found_r;

  logic signed [DW-1:0]         dnum;
  logic signed [DW-1:0]         dden;
  logic [DW-1:0]                mnum;
  logic [DW-1:0]                mden;
  logic [TIME_BITS-1:0]         span0;

  logic [DW-1:0]                rem_nxt;
  logic [TIME_BITS-1:0]         q_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= '0;
      falling_r <= 1'b0;
      last_r    <= 1'b0;
      ws_r      <= '0;
      we_r      <= '1;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_THRESHOLD:    thr_r     <= cfg_data[VALUE_BITS-1:0];
        CFG_FALLING_EDGE: falling_r <= cfg_data[0];
        CFG_REPORT_LAST:  last_r    <= cfg_data[0];
        CFG_WINDOW_START: ws_r      <= cfg_data[TIME_BITS-1:0];
        CFG_WINDOW_END:   we_r      <= cfg_data[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    status.in_window   = (t_r >= ws_r) && (t_r <= we_r);
    status.beyond      = falling_r ? (v_r > thr_r) : (v_r < thr_r);
    status.past        = falling_r ? (v_r < thr_r) : (v_r > thr_r);
    status.eor         = eor_r;
    status.div_last    = (cnt_r == '0);
    status.report_last = last_r;
  end

  always_comb begin
    dnum  = $signed({thr_r[VALUE_BITS-1], thr_r}) - $signed({lv_r[VALUE_BITS-1], lv_r});
    dden  = $signed({v_r[VALUE_BITS-1], v_r}) - $signed({lv_r[VALUE_BITS-1], lv_r});
    mnum  = dnum[DW-1] ? DW'(-dnum) : DW'(dnum);
    mden  = dden[DW-1] ? DW'(-dden) : DW'(dden);
    span0 = (t_r >= lt_r) ? (t_r - lt_r) : '0;
  end

  // Two bits of the span per cycle; the remainder stays below the divisor.
  always_comb begin
    logic [DW+1:0] acc;
    logic [1:0]    k;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    acc     = '0;
    k       = 2'd0;
    for (int i = 0; i < 2; i++) begin
      acc = {1'b0, rem_nxt, 1'b0} + (span_r[SPAN_W-1-i] ? {2'b00, num_r} : '0);
      if (acc >= {1'b0, den_r, 1'b0}) begin
        acc = acc - {1'b0, den_r, 1'b0};
        k   = 2'd2;
      end else if (acc >= {2'b00, den_r}) begin
        acc = acc - {2'b00, den_r};
        k   = 2'd1;
      end else begin
        k   = 2'd0;
      end
      rem_nxt = acc[DW-1:0];
      q_nxt   = {q_nxt[TIME_BITS-2:0], 1'b0} + TIME_BITS'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      t_r   <= in_time;
      v_r   <= in_value;
      eor_r <= in_eor;
    end
    if (cmd.load_lower) begin
      lt_r <= t_r;
      lv_r <= v_r;
    end
    if (cmd.div_start) begin
      num_r  <= mnum;
      den_r  <= mden;
      rem_r  <= '0;
      q_r    <= '0;
      span_r <= SPAN_W'(span0);
      cnt_r  <= CNT_W'(STEPS - 1);
    end else if (cmd.div_step) begin
      span_r <= {span_r[SPAN_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      cnt_r  <= cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        best_r <= lt_r + q_nxt;
      end
    end
    if (cmd.report) begin
      out_time_r  <= found_r ? best_r : '0;
      out_found_r <= found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.report) begin
      found_r <= 1'b0;
    end else if (cmd.div_step && cnt_r == '0) begin
      found_r <= 1'b1;
    end
  end

  assign out_time  = out_time_r;
  assign out_found = out_found_r;

endmodule

// File: src/tctm_ctrl.sv
module tctm_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  tctm_pkg::tctm_status_t status,
  output tctm_pkg::tctm_cmd_t    cmd
);
  import tctm_pkg::*;

  tctm_state_t state_r, state_nxt;
  tctm_phase_t phase_r, phase_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_WAITING;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load_sample = 1'b1;
          state_nxt       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = status.eor ? ST_REPORT : ST_IDLE;
        if (status.in_window && phase_r != PH_DONE) begin
          if (phase_r == PH_WAITING) begin
            if (status.beyond) begin
              cmd.load_lower = 1'b1;
              phase_nxt      = PH_READY;
            end
          end else if (status.past) begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIV;
          end else begin
            cmd.load_lower = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          phase_nxt = status.report_last ? PH_WAITING : PH_DONE;
          state_nxt = status.eor ? ST_REPORT : ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (!out_valid_r || out_ready) begin
          cmd.report = 1'b1;
          phase_nxt  = PH_WAITING;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cmd.report) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
